// File: rtl/pott_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pott_pkg
// Sizes, action codes, result codes and status codes of the task table.
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int CAPACITY    = 16;  // table slots, 2..64
  localparam int ID_BITS     = 16;  // stored id width, 4..32
  localparam int MAX_RESULTS = 16;  // records per scan

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NRS_W = $clog2(MAX_RESULTS + 1);

  localparam int ACT_W  = 3;
  localparam int TID_W  = 16;
  localparam int PRIO_W = 3;
  localparam int STAT_W = 2;
  localparam int CODE_W = 3;

  // actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;

  // result codes
  localparam logic [CODE_W-1:0] RES_DONE      = 3'd0;
  localparam logic [CODE_W-1:0] RES_NOT_FOUND = 3'd1;
  localparam logic [CODE_W-1:0] RES_INVALID   = 3'd2;
  localparam logic [CODE_W-1:0] RES_FULL      = 3'd3;
  localparam logic [CODE_W-1:0] RES_RECORD    = 3'd4;
  localparam logic [CODE_W-1:0] RES_NONE      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_PENDING   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PROGRESS  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_COMPLETED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 2'd3;

endpackage : pott_pkg
`default_nettype wire

// File: rtl/priority_ordered_task_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ordered_task_table
// Task table kept sorted by descending priority, with insert, delete by id,
// status update, search by priority and a list grouped by status.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction:
//   action, task id, priority and status. Output channel
//   (out_valid/out_ready) returns one or more result transactions; the
//   final one of each command has out_last set.
//   One command at a time: in_ready is high only while the sequencer idles.
//   A single read index walks the slots one per cycle, unless an output
//   stall holds a search or list scan. Insert, delete and update stop at
//   the slot they need or at the end; search walks every slot once, list
//   once for each of three status groups, with at most one record leaving
//   per cycle while scanning. Codes 5 to 7 are taken and give no result.
//   Each record is held one step behind the scan, so the last one can be
//   flagged; a stall on the output holds the scan where a record must move.
//   Reset empties the table (count only) and clears all handshake state;
//   slot contents are never read beyond the count and need no clearing.
// ----------------------------------------------------------------------------
module priority_ordered_task_table (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [pott_pkg::ACT_W-1:0]       in_action,
  input  wire  [pott_pkg::TID_W-1:0]       in_task_id,
  input  wire  [pott_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire  [pott_pkg::STAT_W-1:0]      in_status_code,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [pott_pkg::CODE_W-1:0]      out_result_code,
  output logic [pott_pkg::TID_W-1:0]       out_entry_id,
  output logic [pott_pkg::PRIO_W-1:0]      out_entry_priority,
  output logic [pott_pkg::STAT_W-1:0]      out_entry_status,
  output logic                             out_last
);
  import pott_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  // slot storage, valid below cnt_r only
  logic [ID_BITS-1:0] slot_id_r   [CAPACITY];
  logic [PRIO_W-1:0]  slot_prio_r [CAPACITY];
  logic [STAT_W-1:0]  slot_stat_r [CAPACITY];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ACT_W-1:0]   op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [STAT_W-1:0]  grp_r, grp_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               hit_r, hit_nxt;
  logic               full_r, full_nxt;
  logic [NRS_W-1:0]   n_r, n_nxt;

  // pending record, one behind the scan
  logic               pend_valid_r, pend_valid_nxt;
  logic [ID_BITS-1:0] pend_id_r, pend_id_nxt;
  logic [PRIO_W-1:0]  pend_prio_r, pend_prio_nxt;
  logic [STAT_W-1:0]  pend_stat_r, pend_stat_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic [TID_W-1:0]   out_id_r, out_id_nxt;
  logic [PRIO_W-1:0]  out_prio_r, out_prio_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic               out_last_r, out_last_nxt;

  // shared compare unit inputs
  logic [IDX_W-1:0]   rd_idx;
  logic [ID_BITS-1:0] sel_id;
  logic [PRIO_W-1:0]  sel_prio;
  logic [STAT_W-1:0]  sel_stat;
  logic               at_end;
  logic               out_free;
  logic               match;
  logic               take;

  // table write strobes
  logic               tbl_ins, tbl_del, tbl_upd;

  assign rd_idx   = scan_r[IDX_W-1:0];
  assign sel_id   = slot_id_r[rd_idx];
  assign sel_prio = slot_prio_r[rd_idx];
  assign sel_stat = slot_stat_r[rd_idx];
  assign at_end   = (scan_r == cnt_r);
  assign out_free = !out_valid_r || out_ready;

  assign match = (op_r == ACT_SEARCH) ? (sel_prio == prio_r) : (sel_stat == grp_r);
  assign take  = match && (n_r < NRS_W'(MAX_RESULTS));

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_code    = out_code_r;
  assign out_entry_id       = out_id_r;
  assign out_entry_priority = out_prio_r;
  assign out_entry_status   = out_stat_r;
  assign out_last           = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    prio_nxt       = prio_r;
    stat_nxt       = stat_r;
    scan_nxt       = scan_r;
    grp_nxt        = grp_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    full_nxt       = full_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_prio_nxt  = pend_prio_r;
    pend_stat_nxt  = pend_stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_code_nxt   = out_code_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_stat_nxt   = out_stat_r;
    out_last_nxt   = out_last_r;
    tbl_ins        = 1'b0;
    tbl_del        = 1'b0;
    tbl_upd        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_action;
          id_nxt   = ID_BITS'(in_task_id);
          prio_nxt = in_priority_req;
          stat_nxt = in_status_code;
          scan_nxt = '0;
          grp_nxt  = STAT_PENDING;
          n_nxt    = '0;
          hit_nxt  = 1'b0;
          full_nxt = 1'b0;
          // unknown actions are dropped here
          if (in_action <= ACT_LIST) state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        case (op_r) inside
          ACT_INSERT: begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              full_nxt  = 1'b1;
              state_nxt = S_FINISH;
            end else if (at_end || (sel_prio < prio_r)) begin
              pos_nxt   = rd_idx;
              state_nxt = S_FINISH;
            end else begin
              scan_nxt = scan_r + CNT_W'(1);
            end
          end
          ACT_DELETE, ACT_UPDATE: begin
            if (at_end) begin
              state_nxt = S_FINISH;
            end else if (sel_id == id_r) begin
              hit_nxt   = 1'b1;
              pos_nxt   = rd_idx;
              state_nxt = S_FINISH;
            end else begin
              scan_nxt = scan_r + CNT_W'(1);
            end
          end
          default: begin
            // search and list
            if (at_end) begin
              if ((op_r == ACT_SEARCH) || (grp_r == STAT_COMPLETED)) begin
                state_nxt = S_FINISH;
              end else begin
                grp_nxt  = grp_r + STAT_W'(1);
                scan_nxt = '0;
              end
            end else if (!(take && pend_valid_r && !out_free)) begin
              if (take) begin
                if (pend_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_code_nxt  = RES_RECORD;
                  out_id_nxt    = TID_W'(pend_id_r);
                  out_prio_nxt  = pend_prio_r;
                  out_stat_nxt  = pend_stat_r;
                  out_last_nxt  = 1'b0;
                end
                pend_valid_nxt = 1'b1;
                pend_id_nxt    = sel_id;
                pend_prio_nxt  = sel_prio;
                pend_stat_nxt  = sel_stat;
                n_nxt          = n_r + NRS_W'(1);
              end
              scan_nxt = scan_r + CNT_W'(1);
            end
          end
        endcase
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_id_nxt     = '0;
          out_prio_nxt   = '0;
          out_stat_nxt   = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
          case (op_r)
            ACT_INSERT: begin
              if (full_r) begin
                out_code_nxt = RES_FULL;
              end else begin
                out_code_nxt = RES_DONE;
                tbl_ins      = 1'b1;
                cnt_nxt      = cnt_r + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (hit_r) begin
                out_code_nxt = RES_DONE;
                tbl_del      = 1'b1;
                cnt_nxt      = cnt_r - CNT_W'(1);
              end else begin
                out_code_nxt = RES_NOT_FOUND;
              end
            end
            ACT_UPDATE: begin
              if (!hit_r) begin
                out_code_nxt = RES_NOT_FOUND;
              end else if (stat_r == STAT_UNKNOWN) begin
                out_code_nxt = RES_INVALID;
              end else begin
                out_code_nxt = RES_DONE;
                tbl_upd      = 1'b1;
              end
            end
            default: begin
              if (pend_valid_r) begin
                out_code_nxt = RES_RECORD;
                out_id_nxt   = TID_W'(pend_id_r);
                out_prio_nxt = pend_prio_r;
                out_stat_nxt = pend_stat_r;
              end else begin
                out_code_nxt = RES_NONE;
              end
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    stat_r      <= stat_nxt;
    scan_r      <= scan_nxt;
    grp_r       <= grp_nxt;
    pos_r       <= pos_nxt;
    hit_r       <= hit_nxt;
    full_r      <= full_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_prio_r <= pend_prio_nxt;
    pend_stat_r <= pend_stat_nxt;
    out_code_r  <= out_code_nxt;
    out_id_r    <= out_id_nxt;
    out_prio_r  <= out_prio_nxt;
    out_stat_r  <= out_stat_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Table moves: each slot takes its own neighbor, or the new entry.
  always_ff @(posedge clk) begin
    if (tbl_ins) begin
      for (int j = 1; j < CAPACITY; j++) begin
        if (IDX_W'(j) > pos_r) begin
          slot_id_r[j]   <= slot_id_r[j-1];
          slot_prio_r[j] <= slot_prio_r[j-1];
          slot_stat_r[j] <= slot_stat_r[j-1];
        end
      end
      slot_id_r[pos_r]   <= id_r;
      slot_prio_r[pos_r] <= prio_r;
      slot_stat_r[pos_r] <= stat_r;
    end else if (tbl_del) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (IDX_W'(j) >= pos_r) begin
          slot_id_r[j]   <= slot_id_r[j+1];
          slot_prio_r[j] <= slot_prio_r[j+1];
          slot_stat_r[j] <= slot_stat_r[j+1];
        end
      end
    end else if (tbl_upd) begin
      slot_stat_r[pos_r] <= stat_r;
    end
  end

  // checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("pending record left over in idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("occupied count beyond capacity");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NRS_W'(MAX_RESULTS))
    else $error("record count beyond limit");

  a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_code_r == RES_FULL)) |-> (cnt_r == CNT_W'(CAPACITY)))
    else $error("table full reported while not full");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action <= ACT_LIST)) |=> (state_r == S_SCAN))
    else $error("accepted command did not start a scan");

endmodule : priority_ordered_task_table
`default_nettype wire

// File: tb/pott_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pott_checker
// Watches both channels of the task table, keeps its own copy of the table,
// predicts the results of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module pott_checker (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  wire                         in_ready,
  input  wire [pott_pkg::ACT_W-1:0]   in_action,
  input  wire [pott_pkg::TID_W-1:0]   in_task_id,
  input  wire [pott_pkg::PRIO_W-1:0]  in_priority_req,
  input  wire [pott_pkg::STAT_W-1:0]  in_status_code,
  input  wire                         out_valid,
  input  wire                         out_ready,
  input  wire [pott_pkg::CODE_W-1:0]  out_result_code,
  input  wire [pott_pkg::TID_W-1:0]   out_entry_id,
  input  wire [pott_pkg::PRIO_W-1:0]  out_entry_priority,
  input  wire [pott_pkg::STAT_W-1:0]  out_entry_status,
  input  wire                         out_last,
  output int                          mismatch_count,
  output int                          pending_results,
  output int                          results_checked,
  output int                          record_count,
  output int                          full_count
);
  import pott_pkg::*;

  localparam logic [TID_W-1:0] ID_MASK =
    (ID_BITS >= TID_W) ? {TID_W{1'b1}} : TID_W'((64'd1 << ID_BITS) - 64'd1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TID_W-1:0]  id;
    logic [PRIO_W-1:0] prio;
    logic [STAT_W-1:0] stat;
    logic              is_last;
  } task_result_t;

  // shadow table, sorted by descending priority
  logic [TID_W-1:0]  slot_id   [CAPACITY];
  logic [PRIO_W-1:0] slot_prio [CAPACITY];
  logic [STAT_W-1:0] slot_stat [CAPACITY];
  int                slot_count;

  task_result_t expected_results[$];
  task_result_t burst_q[$];

  task automatic add_result(input logic [CODE_W-1:0] code, input logic [TID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio, input logic [STAT_W-1:0] stat);
    task_result_t r;
    r.code    = code;
    r.id      = id;
    r.prio    = prio;
    r.stat    = stat;
    r.is_last = 1'b0;
    // scans stop emitting after MAX_RESULTS records
    if (burst_q.size() < MAX_RESULTS) burst_q.push_back(r);
  endtask

  function automatic int find_slot(input logic [TID_W-1:0] id);
    int i;
    for (i = 0; i < slot_count; i++)
      if (slot_id[i] == id) return i;
    return CAPACITY;
  endfunction

  task automatic predict_command(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid_raw,
                                 input logic [PRIO_W-1:0] prio, input logic [STAT_W-1:0] stat);
    logic [TID_W-1:0] tid;
    task_result_t r;
    int pos, i, g, n;
    tid = tid_raw & ID_MASK;
    burst_q.delete();
    case (act)
      ACT_INSERT: begin
        if (slot_count >= CAPACITY) begin
          add_result(RES_FULL, '0, '0, '0);
        end else begin
          pos = 0;
          while (pos < slot_count && slot_prio[pos] >= prio) pos++;
          for (i = slot_count; i > pos; i--) begin
            slot_id[i]   = slot_id[i-1];
            slot_prio[i] = slot_prio[i-1];
            slot_stat[i] = slot_stat[i-1];
          end
          slot_id[pos]   = tid;
          slot_prio[pos] = prio;
          slot_stat[pos] = stat;
          slot_count++;
          add_result(RES_DONE, '0, '0, '0);
        end
      end
      ACT_DELETE: begin
        pos = find_slot(tid);
        if (pos >= CAPACITY) begin
          add_result(RES_NOT_FOUND, '0, '0, '0);
        end else begin
          for (i = pos; i + 1 < slot_count; i++) begin
            slot_id[i]   = slot_id[i+1];
            slot_prio[i] = slot_prio[i+1];
            slot_stat[i] = slot_stat[i+1];
          end
          slot_count--;
          add_result(RES_DONE, '0, '0, '0);
        end
      end
      ACT_UPDATE: begin
        pos = find_slot(tid);
        if (pos >= CAPACITY) begin
          add_result(RES_NOT_FOUND, '0, '0, '0);
        end else if (stat == STAT_UNKNOWN) begin
          add_result(RES_INVALID, '0, '0, '0);
        end else begin
          slot_stat[pos] = stat;
          add_result(RES_DONE, '0, '0, '0);
        end
      end
      ACT_SEARCH: begin
        for (i = 0; i < slot_count; i++)
          if (slot_prio[i] == prio) add_result(RES_RECORD, slot_id[i], slot_prio[i], slot_stat[i]);
        if (burst_q.size() == 0) add_result(RES_NONE, '0, '0, '0);
      end
      ACT_LIST: begin
        // pending first, then in progress, then completed; unknown never listed
        for (g = STAT_PENDING; g <= STAT_COMPLETED; g++)
          for (i = 0; i < slot_count; i++)
            if (slot_stat[i] == g) add_result(RES_RECORD, slot_id[i], slot_prio[i], slot_stat[i]);
        if (burst_q.size() == 0) add_result(RES_NONE, '0, '0, '0);
      end
      default: ;  // unused codes: no result, no change
    endcase
    n = burst_q.size();
    for (i = 0; i < n; i++) begin
      r = burst_q[i];
      r.is_last = (i == n - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got,
                           inout bit bad);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic check_result(input task_result_t got);
    task_result_t want;
    bit bad;
    bad = 1'b0;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual code=%0d id=%0h prio=%0d stat=%0d last=%0b",
               $time, got.code, got.id, got.prio, got.stat, got.is_last);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      cmp_field("result_code", want.code, got.code, bad);
      cmp_field("entry_id", want.id, got.id, bad);
      cmp_field("entry_priority", want.prio, got.prio, bad);
      cmp_field("entry_status", want.stat, got.stat, bad);
      cmp_field("last", want.is_last, got.is_last, bad);
      if (bad) mismatch_count++;
    end
    results_checked++;
    if (got.code == RES_RECORD) record_count++;
    if (got.code == RES_FULL) full_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count = 0;
      expected_results.delete();
      mismatch_count  = 0;
      results_checked = 0;
      record_count    = 0;
      full_count      = 0;
    end else begin
      if (out_valid && out_ready)
        check_result({out_result_code, out_entry_id, out_entry_priority,
                      out_entry_status, out_last});
      if (in_valid && in_ready)
        predict_command(in_action, in_task_id, in_priority_req, in_status_code);
    end
    pending_results <= expected_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the priority-ordered task table: a directed pass
// over empty, tie, duplicate and invalid cases, then random episodes that
// fill, churn and drain the table under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import pott_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 140;
  localparam int EPISODE_LEN  = 30;
  localparam int LONG_HOLD    = 400;
  // worst case: list walks three passes over the table
  localparam int DRAIN_CYCLES = 3 * (CAPACITY + 1) + 1 + 16;
  // ~175 commands x (gap + list scan + 16 results, each behind the longest
  // stall) plus the long hold, taken several times over
  localparam int CYCLE_LIMIT  = 500000;

  // codes past ACT_LIST are not used by the block and must be ignored
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_LIST + 3'd1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = {ACT_W{1'b1}};

  typedef enum int {EP_FILL, EP_MIXED, EP_DRAIN} episode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [ACT_W-1:0]   in_action = '0;
  logic [TID_W-1:0]   in_task_id = '0;
  logic [PRIO_W-1:0]  in_priority_req = '0;
  logic [STAT_W-1:0]  in_status_code = '0;
  logic               out_ready = 1'b0;

  wire                in_ready;
  wire                out_valid;
  wire [CODE_W-1:0]   out_result_code;
  wire [TID_W-1:0]    out_entry_id;
  wire [PRIO_W-1:0]   out_entry_priority;
  wire [STAT_W-1:0]   out_entry_status;
  wire                out_last;

  int mismatches, pending, checked, records, fulls;

  // stimulus state
  bit               idle_on = 1'b1;  // cleared for stretches with no gaps
  int               hold_cycles = 0; // one-shot long stall for the receiver
  int               cycle_count = 0;
  int               commands_sent = 0;
  int               ignored_sent = 0;
  logic [TID_W-1:0] live_ids[$];     // ids the table holds, one per entry

  always #HALF_PERIOD clk = ~clk;

  priority_ordered_task_table uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_task_id         (in_task_id),
    .in_priority_req    (in_priority_req),
    .in_status_code     (in_status_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_code    (out_result_code),
    .out_entry_id       (out_entry_id),
    .out_entry_priority (out_entry_priority),
    .out_entry_status   (out_entry_status),
    .out_last           (out_last)
  );

  pott_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_task_id         (in_task_id),
    .in_priority_req    (in_priority_req),
    .in_status_code     (in_status_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_code    (out_result_code),
    .out_entry_id       (out_entry_id),
    .out_entry_priority (out_entry_priority),
    .out_entry_status   (out_entry_status),
    .out_last           (out_last),
    .mismatch_count     (mismatches),
    .pending_results    (pending),
    .results_checked    (checked),
    .record_count       (records),
    .full_count         (fulls)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Per-transaction random wait; at least a third of the draws give no gap so
  // back-to-back transfers show up even while idling is on.
  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Offer one command and hold it until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the transaction, so a
  // zero gap keeps in_valid high into the next command.
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid,
                          input logic [PRIO_W-1:0] prio, input logic [STAT_W-1:0] stat);
    int gap, k;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_task_id      <= tid;
    in_priority_req <= prio;
    in_status_code  <= stat;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
    // Mirror the occupancy so random deletes and updates can aim at live ids.
    if (act == ACT_INSERT && live_ids.size() < CAPACITY) begin
      live_ids.push_back(tid);
    end else if (act == ACT_DELETE) begin
      for (k = 0; k < live_ids.size(); k++)
        if (live_ids[k] == tid) begin
          live_ids.delete(k);
          break;
        end
    end else if (act > ACT_LIST) begin
      ignored_sent++;
    end
  endtask

  // Mostly an id the table holds, so delete and update land on entries.
  function automatic logic [TID_W-1:0] pick_known_id(input logic [TID_W-1:0] fallback);
    if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    return fallback;
  endfunction

  task automatic random_cmd(input episode_t ep, output bit ignored);
    int r, ins_lim, del_lim, upd_lim, srch_lim, list_lim;
    logic [ACT_W-1:0]  act;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic [STAT_W-1:0] stat;
    // cumulative percentages per action; the remainder is unused codes
    case (ep)
      EP_FILL:  begin ins_lim = 65; del_lim = 70; upd_lim = 78; srch_lim = 86; list_lim = 95; end
      EP_DRAIN: begin ins_lim = 15; del_lim = 55; upd_lim = 70; srch_lim = 80; list_lim = 93; end
      default:  begin ins_lim = 30; del_lim = 45; upd_lim = 62; srch_lim = 78; list_lim = 94; end
    endcase
    r    = $urandom_range(0, 99);
    tid  = TID_W'($urandom_range(0, 65535));
    prio = PRIO_W'($urandom_range(0, 7));
    stat = STAT_W'($urandom_range(0, 3));
    if (r < ins_lim) begin
      act = ACT_INSERT;
      // normal priorities dominate so ties are common
      if ($urandom_range(0, 3) != 0) prio = PRIO_W'($urandom_range(1, 5));
      // occasional duplicate id
      if (live_ids.size() > 0 && $urandom_range(0, 7) == 0)
        tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
    end else if (r < del_lim) begin
      act = ACT_DELETE;
      tid = pick_known_id(tid);
    end else if (r < upd_lim) begin
      act = ACT_UPDATE;
      tid = pick_known_id(tid);
    end else if (r < srch_lim) begin
      act = ACT_SEARCH;
      if ($urandom_range(0, 3) != 0) prio = PRIO_W'($urandom_range(1, 5));
    end else if (r < list_lim) begin
      act = ACT_LIST;
    end else begin
      act = ACT_UNUSED_LO + ACT_W'($urandom_range(0, ACT_UNUSED_HI - ACT_UNUSED_LO));
    end
    ignored = (act > ACT_LIST);
    send_cmd(act, tid, prio, stat);
  endtask

  // Result side: random stall before each transaction, plus the long hold
  // when one is requested. While it holds, the sender keeps offering and
  // the block, busy on one command, keeps in_ready low.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap() + hold_cycles;
      hold_cycles = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int ep_idx, done_items, j;
    bit ign;
    episode_t ep;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // empty table: every scan and lookup misses
    send_cmd(ACT_LIST,   16'h0000, 3'd0, STAT_PENDING);
    send_cmd(ACT_SEARCH, 16'h0000, 3'd3, STAT_PENDING);
    send_cmd(ACT_DELETE, 16'h1234, 3'd0, STAT_PENDING);
    send_cmd(ACT_UPDATE, 16'h1234, 3'd0, STAT_PROGRESS);
    // extremes of id and priority, unknown status stored as given,
    // equal priorities placed after existing ones, a duplicate id
    send_cmd(ACT_INSERT, 16'h0000, 3'd0, STAT_PENDING);
    send_cmd(ACT_INSERT, 16'hFFFF, 3'd7, STAT_UNKNOWN);
    send_cmd(ACT_INSERT, 16'h00A5, 3'd3, STAT_PROGRESS);
    send_cmd(ACT_INSERT, 16'h5A00, 3'd3, STAT_COMPLETED);
    send_cmd(ACT_INSERT, 16'h00A5, 3'd5, STAT_PENDING);
    send_cmd(ACT_INSERT, 16'h8001, 3'd6, STAT_PROGRESS);
    send_cmd(ACT_SEARCH, 16'hFFFF, 3'd3, STAT_UNKNOWN);
    send_cmd(ACT_SEARCH, 16'h0000, 3'd7, STAT_PENDING);
    send_cmd(ACT_SEARCH, 16'h0000, 3'd0, STAT_PENDING);
    send_cmd(ACT_LIST,   16'hFFFF, 3'd7, STAT_UNKNOWN);
    // rejected status, then updates that hit the first matching id
    send_cmd(ACT_UPDATE, 16'h00A5, 3'd0, STAT_UNKNOWN);
    send_cmd(ACT_UPDATE, 16'h00A5, 3'd0, STAT_COMPLETED);
    send_cmd(ACT_UPDATE, 16'hFFFF, 3'd0, STAT_PENDING);
    // unused action codes are swallowed without a result
    send_cmd(ACT_UNUSED_LO,        16'hFFFF, 3'd7, STAT_UNKNOWN);
    send_cmd(ACT_UNUSED_LO + 3'd1, 16'h00A5, 3'd3, STAT_PROGRESS);
    send_cmd(ACT_UNUSED_HI,        16'h0000, 3'd0, STAT_PENDING);
    // delete duplicates one by one, then miss
    send_cmd(ACT_DELETE, 16'h00A5, 3'd0, STAT_PENDING);
    send_cmd(ACT_DELETE, 16'h00A5, 3'd0, STAT_PENDING);
    send_cmd(ACT_DELETE, 16'h00A5, 3'd0, STAT_PENDING);
    send_cmd(ACT_LIST,   16'h0000, 3'd0, STAT_PENDING);
    send_cmd(ACT_SEARCH, 16'h0000, 3'd3, STAT_PENDING);

    // --- random episodes: fill to full, churn, drain, repeat ---
    done_items = 0;
    ep_idx = 0;
    while (done_items < RANDOM_ITEMS) begin
      case (ep_idx % 3)
        0:       ep = EP_FILL;
        1:       ep = EP_MIXED;
        default: ep = EP_DRAIN;
      endcase
      idle_on = (ep_idx % 5 != 3);           // one episode runs flat out
      if (ep_idx == 2) hold_cycles = LONG_HOLD; // long receiver stall
      j = 0;
      while (j < EPISODE_LEN && done_items < RANDOM_ITEMS) begin
        random_cmd(ep, ign);
        if (!ign) begin
          done_items++;
          j++;
        end
      end
      ep_idx++;
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    // let the checker's pending count catch up, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands (%0d with unused action codes) over %0d cycles.",
             commands_sent, ignored_sent, cycle_count);
    $display("Checked %0d results: %0d entry records, %0d table-full answers, %0d mismatches.",
             checked, records, fulls, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
